// ===== src/gbm_path_option_payoff_unit_defines.svh =====
// Assertion macros used by the checker file
`ifndef GBM_PATH_OPTION_PAYOFF_UNIT_DEFINES_SVH
`define GBM_PATH_OPTION_PAYOFF_UNIT_DEFINES_SVH

// Implication checked on every clock, reset disables
`define GBM_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication checked on every clock, reset disables
`define GBM_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ===== src/gbm_pkg.sv =====
package gbm_pkg;

  localparam int PriceW = 40;
  localparam int SumW = 52;
  localparam int CoefW = 32;
  localparam int SampW = 16;
  localparam int AddrW = 5;
  localparam int ExpTerms = 12;

  localparam logic [PriceW-1:0] PriceMax = {PriceW{1'b1}};
  localparam logic [31:0] OneQ30 = 32'd1073741824;
  localparam logic [31:0] Ln2Q30 = 32'd744261118;

  // register indexes
  localparam logic [2:0] RegDrift = 3'd0;
  localparam logic [2:0] RegDiff = 3'd1;
  localparam logic [2:0] RegDisc = 3'd2;
  localparam logic [2:0] RegSpot = 3'd3;
  localparam logic [2:0] RegStrike = 3'd4;
  localparam logic [2:0] RegSteps = 3'd5;
  localparam logic [2:0] RegAsian = 3'd6;
  localparam logic [2:0] RegMode = 3'd7;

  localparam logic [1:0] ModePlain = 2'd0;
  localparam logic [1:0] ModeNegOdd = 2'd1;
  localparam logic [1:0] ModePair = 2'd2;

  typedef struct packed {
    logic [SampW-1:0] normal_sample;
    logic scenario_odd;
  } in_item_t;

  typedef struct packed {
    logic [PriceW-1:0] payoff;
    logic path_status;
  } out_item_t;

  // reciprocal table 1/i in Q.32 for the Taylor division, i = 1..12 (index 0 unused)
  function automatic logic [32:0] recip_q32(input logic [3:0] i);
    logic [32:0] r;
    case (i)
      4'd1: r = 33'h1_0000_0000;
      4'd2: r = 33'h0_8000_0000;
      4'd3: r = 33'h0_5555_5556;
      4'd4: r = 33'h0_4000_0000;
      4'd5: r = 33'h0_3333_3334;
      4'd6: r = 33'h0_2AAA_AAAB;
      4'd7: r = 33'h0_2492_4925;
      4'd8: r = 33'h0_2000_0000;
      4'd9: r = 33'h0_1C71_C71D;
      4'd10: r = 33'h0_1999_999A;
      4'd11: r = 33'h0_1745_D175;
      4'd12: r = 33'h0_1555_5556;
      default: r = 33'h1_0000_0000;
    endcase
    return r;
  endfunction

endpackage

// ===== src/gbm_if.sv =====
interface gbm_in_if;
  logic valid;
  logic ready;
  logic [gbm_pkg::SampW-1:0] normal_sample;
  logic scenario_odd;
  modport source (output valid, normal_sample, scenario_odd, input ready);
  modport sink (input valid, normal_sample, scenario_odd, output ready);
endinterface

interface gbm_out_if;
  logic valid;
  logic ready;
  logic [gbm_pkg::PriceW-1:0] payoff;
  logic path_status;
  modport source (output valid, payoff, path_status, input ready);
  modport sink (input valid, payoff, path_status, output ready);
endinterface

// ===== src/gbm_div.sv =====
// Restoring divider: quo = num / den, one quotient bit per cycle
module gbm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [51:0] num,
  input  logic [12:0] den,
  output logic        done,
  output logic [51:0] quo
);
  logic [5:0]  cnt;
  logic        busy;
  logic [13:0] rem;
  logic [51:0] q;
  logic [13:0] trial;
  logic [13:0] diff;

  assign trial = {rem[12:0], q[51]};
  assign diff = trial - {1'b0, den};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        q <= num;
        rem <= '0;
      end else if (busy) begin
        // shift in next bit, subtract when it fits
        if (!diff[13]) begin
          rem <= diff;
          q <= {q[50:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[50:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd51) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== src/gbm_path_option_payoff_unit.sv =====
// GBM path option payoff unit.
// Input channel in_ch (valid/ready) carries one Q4.12 normal sample per time
// step plus the scenario parity bit. Output channel out_ch carries one payoff
// (Q24.16, discounted, saturating) and a status bit at the last step of each
// path; other steps give no result. An APB write port sets the eight
// coefficient and mode registers at byte address 8*i; reads return them.
// Each step runs a sequencer over one shared 32x33 multiplier: exponent,
// range reduction by ln2, 12 Taylor terms (two multiplies each), the price
// product in two halves, shift and commit; in pair mode the steps from
// exponent to shift run again for the mirror path unless the main side
// faults. A step on a faulted path goes from idle straight to commit. The
// last step adds the payoff phase, which in Asian mode waits for a
// bit-serial divider.
// in_ch.ready is high only while the sequencer is idle.
// Reset restores the configuration and path state and starts a new path
// at spot price. If out_ch stalls, the result holds in the output register;
// items are still taken until the next path end, which waits for it.
module gbm_path_option_payoff_unit #(
  parameter int MAX_STEPS = 4096
) (
  input  logic clk,
  input  logic rst,
  gbm_in_if.sink  in_ch,
  gbm_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [gbm_pkg::AddrW:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam logic signed [35:0] Ln2S = 36'(gbm_pkg::Ln2Q30);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_EXPM  = 11'b00000000010,
    S_RED   = 11'b00000000100,
    S_TMUL  = 11'b00000001000,
    S_TDIV  = 11'b00000010000,
    S_PMUL  = 11'b00000100000,
    S_SHIFT = 11'b00001000000,
    S_COMMIT= 11'b00010000000,
    S_AVG   = 11'b00100000000,
    S_DISC  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  // configuration
  logic signed [31:0] drift;
  logic [30:0] diffusion;
  logic [31:0] discount;
  logic [39:0] spot, strike;
  logic [12:0] num_steps;
  logic asian;
  logic [1:0] mode;
  logic wr;
  logic [2:0] widx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign widx = paddr[gbm_pkg::AddrW:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      drift <= '0; diffusion <= '0; discount <= gbm_pkg::OneQ30;
      spot <= 40'd6553600; strike <= 40'd6553600; num_steps <= 13'd1;
      asian <= 1'b0; mode <= gbm_pkg::ModePlain;
    end else if (wr) begin
      case (widx)
        gbm_pkg::RegDrift: drift <= pwdata[31:0];
        gbm_pkg::RegDiff: diffusion <= pwdata[30:0];
        gbm_pkg::RegDisc: discount <= pwdata[31:0];
        gbm_pkg::RegSpot: spot <= pwdata[39:0];
        gbm_pkg::RegStrike: strike <= pwdata[39:0];
        gbm_pkg::RegSteps: num_steps <= pwdata[12:0];
        gbm_pkg::RegAsian: asian <= pwdata[0];
        gbm_pkg::RegMode: mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      gbm_pkg::RegDrift: prdata = {32'd0, drift};
      gbm_pkg::RegDiff: prdata = {33'd0, diffusion};
      gbm_pkg::RegDisc: prdata = {32'd0, discount};
      gbm_pkg::RegSpot: prdata = {24'd0, spot};
      gbm_pkg::RegStrike: prdata = {24'd0, strike};
      gbm_pkg::RegSteps: prdata = {51'd0, num_steps};
      gbm_pkg::RegAsian: prdata = {63'd0, asian};
      gbm_pkg::RegMode: prdata = {62'd0, mode};
      default: prdata = '0;
    endcase
  end

  // effective step count
  logic [12:0] n_eff;
  always_comb begin
    if (num_steps == 13'd0) n_eff = 13'd1;
    else if ({{(32-13){1'b0}}, num_steps} > 32'(MAX_STEPS)) n_eff = 13'(MAX_STEPS);
    else n_eff = num_steps;
  end

  // shared multiplier, 32 x 33 unsigned
  logic [31:0] ma;
  logic [32:0] mb;
  logic [64:0] mp;
  assign mp = ma * mb;

  // path state
  state_t state;
  logic [39:0] main_price, mirror_price;
  logic [51:0] main_sum, mirror_sum;
  logic [NW-1:0] step_index;
  logic path_fault;

  // step working registers
  logic signed [16:0] z;
  logic side;           // 0 main, 1 mirror
  logic [39:0] np;      // main candidate
  logic ok;
  logic signed [35:0] e;
  logic signed [7:0] k;
  logic [31:0] r, term, acc;
  logic [3:0] ti;
  logic [40:0] m;
  logic pair;
  logic [39:0] v0;
  logic [42:0] vsum;
  logic half;           // 0 low 20 bits, 1 high 20 bits of a wide product
  logic [32:0] lo_part;
  logic out_valid;
  logic [39:0] out_payoff;
  logic out_status;

  // divider for the Asian average
  logic div_start, div_done;
  logic [51:0] div_num, div_quo;
  gbm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(n_eff), .done(div_done), .quo(div_quo)
  );

  assign pair = mode == gbm_pkg::ModePair;
  assign in_ch.ready = state == S_IDLE;
  assign out_ch.valid = out_valid;
  assign out_ch.payoff = out_payoff;
  assign out_ch.path_status = out_status;

  // signed sample for the active side
  logic signed [16:0] zs;
  logic [16:0] zmag;
  assign zs = side ? -z : z;
  assign zmag = zs[16] ? -zs : zs;

  logic [39:0] pmx;
  assign pmx = side ? mirror_price : main_price;

  // multiplier operand select
  always_comb begin
    ma = '0; mb = '0;
    case (state)
      S_EXPM: begin ma = {15'd0, zmag}; mb = {2'd0, diffusion}; end
      S_TMUL: begin ma = term; mb = {1'b0, r}; end
      S_TDIV: begin ma = term; mb = gbm_pkg::recip_q32(ti); end
      S_PMUL: begin ma = {12'd0, half ? pmx[39:20] : pmx[19:0]}; mb = {1'b0, acc}; end
      S_DISC: begin ma = {12'd0, half ? v0[39:20] : v0[19:0]}; mb = {1'b0, discount}; end
      default: ;
    endcase
  end

  logic [34:0] tround;
  assign tround = 35'((mp[47:0] + 48'd2048) >> 12);

  // floor(x * y / 2^30) from the high half product and the saved low half
  logic [64:0] mq30;
  assign mq30 = (mp + {32'd0, lo_part}) >> 10;

  logic [39:0] base, diffp;
  always_comb begin
    base = asian ? div_quo[39:0] : pmx;
    if (asian && div_quo[51:40] != 12'd0) base = 40'd0;
    diffp = 40'd0;
    if (asian) begin
      if (div_quo > {12'd0, strike}) diffp = 40'(div_quo - {12'd0, strike});
    end else if (base > strike) diffp = base - strike;
  end

  logic [42:0] vres;
  assign vres = pair ? (vsum >> 1) : vsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      main_price <= 40'd6553600; mirror_price <= 40'd6553600;
      main_sum <= '0; mirror_sum <= '0; step_index <= '0; path_fault <= 1'b0;
      out_valid <= 1'b0; div_start <= 1'b0; half <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          z <= (mode == gbm_pkg::ModeNegOdd && in_ch.scenario_odd) ?
               -{in_ch.normal_sample[15], in_ch.normal_sample} :
               {in_ch.normal_sample[15], in_ch.normal_sample};
          side <= 1'b0;
          ok <= 1'b1;
          state <= path_fault ? S_COMMIT : S_EXPM;
        end
        S_EXPM: begin
          // exponent = drift + round(diffusion * z)
          e <= 36'(drift) + (zs[16] ? -$signed({1'b0, tround})
                                    : $signed({1'b0, tround}));
          k <= '0;
          state <= S_RED;
        end
        S_RED: begin
          // bring e into [0, ln2), one ln2 per cycle (|e| stays under 27 ln2)
          if (e < 0) begin
            e <= e + Ln2S; k <= k - 8'sd1;
          end else if (e >= Ln2S) begin
            e <= e - Ln2S; k <= k + 8'sd1;
          end else begin
            r <= e[31:0]; term <= gbm_pkg::OneQ30; acc <= gbm_pkg::OneQ30;
            ti <= 4'd1; state <= S_TMUL;
          end
        end
        S_TMUL: begin
          term <= 32'(mp >> 30);
          state <= S_TDIV;
        end
        S_TDIV: begin
          // floor(term / i) via reciprocal, then correct
          logic [31:0] q;
          q = 32'(mp >> 32);
          if (({16'd0, q} + 48'd1) * ti <= {16'd0, term}) q = q + 32'd1;
          else if ({16'd0, q} * ti > {16'd0, term}) q = q - 32'd1;
          term <= q;
          acc <= acc + q;
          if (ti == 4'(gbm_pkg::ExpTerms)) state <= S_PMUL;
          else begin ti <= ti + 4'd1; state <= S_TMUL; end
        end
        S_PMUL: begin
          // low half first, then high half plus the saved low part
          if (!half) begin
            lo_part <= 33'(mp >> 20);
            half <= 1'b1;
          end else begin
            half <= 1'b0;
            m <= 41'(mq30);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          logic [39:0] res;
          logic good;
          good = 1'b1; res = 40'd0;
          if (k >= 0) begin
            if (k >= 8'sd40 || m > {1'b0, gbm_pkg::PriceMax >> k}) good = 1'b0;
            else res = 40'(m << k);
          end else begin
            res = 40'(m >> (-k));
          end
          if (res == 40'd0) good = 1'b0;
          if (!side) begin
            np <= res;
            if (good && pair) begin side <= 1'b1; state <= S_EXPM; end
            else begin ok <= good; state <= S_COMMIT; end
          end else begin
            ok <= good;
            m <= {1'b0, res};
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (!path_fault) begin
            if (ok) begin
              main_price <= np; main_sum <= main_sum + {12'd0, np};
              if (pair) begin
                mirror_price <= m[39:0]; mirror_sum <= mirror_sum + {12'd0, m[39:0]};
              end
            end else path_fault <= 1'b1;
          end
          if ({{(32-NW){1'b0}}, step_index} + 32'd1 < {19'd0, n_eff}) begin
            step_index <= step_index + 1'b1;
            state <= S_IDLE;
          end else begin
            side <= 1'b0;
            state <= S_AVG;
            div_start <= 1'b1;
          end
        end
        S_AVG: begin
          // in Asian mode, wait for the path sum (now committed) to pass through the divider
          if (!asian || div_done) state <= S_DISC;
        end
        S_DISC: begin
          logic [42:0] dv;
          dv = 43'(mq30);
          if (!half) begin
            lo_part <= 33'(mp >> 20);
            half <= 1'b1;
          end else begin
            half <= 1'b0;
            if (!side) begin
              vsum <= dv;
              if (pair) begin side <= 1'b1; div_start <= 1'b1; state <= S_AVG; end
              else state <= S_EMIT;
            end else begin
              vsum <= vsum + dv;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: if (!out_valid || out_ch.ready) begin
          // hold until the output register is free
          out_valid <= 1'b1;
          out_status <= path_fault;
          out_payoff <= path_fault ? 40'd0 :
                        (vres > {3'd0, gbm_pkg::PriceMax}) ? gbm_pkg::PriceMax : vres[39:0];
          main_price <= spot; mirror_price <= spot;
          main_sum <= '0; mirror_sum <= '0; step_index <= '0; path_fault <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // discount operand: difference for current side
  always_ff @(posedge clk) begin
    if (state == S_AVG) v0 <= diffp;
  end

  assign div_num = (side || (state == S_DISC && pair)) ? mirror_sum : main_sum;
endmodule

// ===== src/gbm_chk.sv =====
`include "gbm_path_option_payoff_unit_defines.svh"
module gbm_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_status,
  input logic [39:0] out_payoff
);
  `GBM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_payoff), "result dropped while stalled")
  `GBM_ASSERT_IMP(a_fault_zero, clk, rst, out_valid && out_status, out_payoff == 40'd0, "faulted path gives nonzero payoff")
  `GBM_ASSERT_NXT(a_status_hold, clk, rst, out_valid && !out_ready, $stable(out_status), "status changed while stalled")
  `GBM_ASSERT_NXT(a_busy_after, clk, rst, in_valid && in_ready, !in_ready, "ready stays high after transfer")
endmodule

bind gbm_path_option_payoff_unit gbm_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.path_status), .out_payoff(out_ch.payoff)
);

// ===== dv/gbm_path_option_payoff_unit_test.sv =====
`timescale 1ns / 1ps

module gbm_path_option_payoff_unit_test;

  localparam longint unsigned PMAX = 64'hFF_FFFF_FFFF;
  localparam longint LN2 = 744261118;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [gbm_pkg::AddrW:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  gbm_in_if in_ch ();
  gbm_out_if out_ch ();

  gbm_path_option_payoff_unit u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register copy
  longint drift;
  longint unsigned diffusion, discount, spot, strike, steps_reg, asian, mode;
  // path state copy
  longint unsigned price_a, sum_a, price_b, sum_b, step_no;
  bit faulted;

  gbm_pkg::in_item_t pending_samples[$];
  gbm_pkg::out_item_t expected_payoffs[$];
  int mismatches;
  int long_hold_req;
  bit no_gaps;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // floor(x*y / 2^30)
  function automatic longint unsigned mul_q30(longint unsigned x, longint unsigned y);
    longint unsigned a, b;
    a = (x >> 20) * y;
    b = (x & 64'hFFFFF) * y;
    return (a + (b >> 20)) >> 10;
  endfunction

  // Taylor sum of exp(r) in Q.30
  function automatic longint unsigned taylor_exp(longint unsigned r);
    longint unsigned term, acc;
    term = 64'd1073741824;
    acc = term;
    for (int i = 1; i <= gbm_pkg::ExpTerms; i++) begin
      term = ((term * r) >> 30) / i;
      acc += term;
    end
    return acc;
  endfunction

  // grow price by exp(e); return 0 on fault
  function automatic bit grow_price(longint unsigned price, longint e,
                                    output longint unsigned nxt);
    longint k, r, s;
    longint unsigned m;
    k = e / LN2;
    if (e % LN2 < 0) k -= 1;
    r = e - k * LN2;
    m = mul_q30(price, taylor_exp(longint'(r)));
    nxt = 0;
    if (k >= 0) begin
      if (k >= 40 || m > (PMAX >> k)) return 1'b0;
      m = m << k;
    end else begin
      s = -k;
      m = (s >= 64) ? 0 : (m >> s);
    end
    if (m == 0) return 1'b0;
    nxt = m;
    return 1'b1;
  endfunction

  function automatic longint log_step(longint z);
    longint unsigned mag;
    longint t;
    mag = longint'(z < 0 ? -z : z) * diffusion;
    t = longint'((mag + 2048) >> 12);
    return drift + (z < 0 ? -t : t);
  endfunction

  function automatic longint unsigned discounted(longint unsigned price,
      longint unsigned sum, longint unsigned n);
    longint unsigned base, diff;
    base = asian ? sum / n : price;
    diff = base > strike ? base - strike : 0;
    return mul_q30(diff & PMAX, discount);
  endfunction

  function automatic void restart_paths();
    price_a = spot;
    price_b = spot;
    sum_a = 0;
    sum_b = 0;
    step_no = 0;
    faulted = 1'b0;
  endfunction

  // registers and path at reset
  function automatic void ref_defaults();
    drift = 0;
    diffusion = 0;
    discount = 64'd1073741824;
    spot = 64'd6553600;
    strike = 64'd6553600;
    steps_reg = 1;
    asian = 0;
    mode = 0;
    restart_paths();
  endfunction

  function automatic void load_reg(int idx, longint unsigned v);
    case (idx)
      gbm_pkg::RegDrift: drift = longint'(v[31:0]) - (v[31] ? 64'sh1_0000_0000 : 0);
      gbm_pkg::RegDiff: diffusion = v & 64'h7FFF_FFFF;
      gbm_pkg::RegDisc: discount = v & 64'hFFFF_FFFF;
      gbm_pkg::RegSpot: spot = v & PMAX;
      gbm_pkg::RegStrike: strike = v & PMAX;
      gbm_pkg::RegSteps: steps_reg = v & 64'h1FFF;
      gbm_pkg::RegAsian: asian = v & 1;
      gbm_pkg::RegMode: mode = v & 3;
      default: ;
    endcase
  endfunction

  // advance the path by one sample, queue the payoff at path end
  function automatic void step_paths(gbm_pkg::in_item_t it);
    longint z;
    longint unsigned n, na, nb, v;
    bit ok, pair;
    gbm_pkg::out_item_t res;
    z = longint'($signed(it.normal_sample));
    pair = (mode == gbm_pkg::ModePair);
    n = steps_reg;
    if (n == 0) n = 1;
    if (n > 4096) n = 4096;
    if (mode == gbm_pkg::ModeNegOdd && it.scenario_odd) z = -z;
    if (!faulted) begin
      ok = grow_price(price_a, log_step(z), na);
      if (ok && pair) ok = grow_price(price_b, log_step(-z), nb);
      if (ok) begin
        price_a = na;
        sum_a += na;
        if (pair) begin
          price_b = nb;
          sum_b += nb;
        end
      end else begin
        faulted = 1'b1;
      end
    end
    if (step_no + 1 < n) begin
      step_no++;
      return;
    end
    if (faulted) begin
      res.payoff = '0;
      res.path_status = 1'b1;
    end else begin
      v = discounted(price_a, sum_a, n);
      if (pair) v = (v + discounted(price_b, sum_b, n)) >> 1;
      res.payoff = (v > PMAX) ? PMAX[39:0] : v[39:0];
      res.path_status = 1'b0;
    end
    expected_payoffs.push_back(res);
    restart_paths();
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // sample driver: predict on each transfer, then offer the next item
  int in_gap;
  always @(posedge clk) begin
    logic nxt_valid;
    gbm_pkg::in_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.normal_sample <= '0;
      in_ch.scenario_odd <= 1'b0;
      in_gap <= 0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        it.normal_sample = in_ch.normal_sample;
        it.scenario_odd = in_ch.scenario_odd;
        step_paths(it);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_samples.size() > 0) begin
          it = pending_samples.pop_front();
          in_ch.normal_sample <= it.normal_sample;
          in_ch.scenario_odd <= it.scenario_odd;
          nxt_valid = 1'b1;
          in_gap <= gap_len();
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // payoff monitor with random back-pressure
  int out_hold;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_payoffs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected payoff %h status %b", out_ch.payoff, out_ch.path_status);
        end else begin
          gbm_pkg::out_item_t e;
          e = expected_payoffs.pop_front();
          if (e.payoff !== out_ch.payoff || e.path_status !== out_ch.path_status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("payoff mismatch: expected %h/%b got %h/%b",
                       e.payoff, e.path_status, out_ch.payoff, out_ch.path_status);
          end
        end
      end
      if (long_hold_req > 0) begin
        out_hold <= long_hold_req;
        long_hold_req <= 0;
        out_ch.ready <= 1'b0;
      end else if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_ch.ready <= 1'b0;
      end else if (!no_gaps && gap_len() > 0) begin
        out_hold <= gap_len();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(int idx, longint unsigned v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (gbm_pkg::AddrW + 1)'(idx * 8);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    load_reg(idx, v);
  endtask

  task automatic configure(longint unsigned dr, longint unsigned df, longint unsigned dc,
                           longint unsigned sp, longint unsigned sk, longint unsigned ns,
                           longint unsigned as, longint unsigned md);
    reg_write(gbm_pkg::RegDrift, dr);
    reg_write(gbm_pkg::RegDiff, df);
    reg_write(gbm_pkg::RegDisc, dc);
    reg_write(gbm_pkg::RegSpot, sp);
    reg_write(gbm_pkg::RegStrike, sk);
    reg_write(gbm_pkg::RegSteps, ns);
    reg_write(gbm_pkg::RegAsian, as);
    reg_write(gbm_pkg::RegMode, md);
  endtask

  task automatic push_sample(logic [15:0] z, logic odd);
    gbm_pkg::in_item_t it;
    it.normal_sample = z;
    it.scenario_odd = odd;
    pending_samples.push_back(it);
  endtask

  // let everything drain so registers can change safely
  task automatic settle();
    while (pending_samples.size() > 0 || in_ch.valid || expected_payoffs.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8192) - 4096);
  endfunction

  function automatic longint unsigned rand_price();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom} & PMAX;
    return longint'($urandom_range(50, 200)) << 16;
  endfunction

  initial begin
    int sent;
    longint unsigned ns;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    long_hold_req = 0;
    no_gaps = 1'b0;
    ref_defaults();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // European, sample extremes
    configure(1000, 21474836, 1020054733, 100 << 16, 90 << 16, 1, 0, gbm_pkg::ModePlain);
    push_sample(16'h7FFF, 0); push_sample(16'h8000, 1); push_sample(16'h0000, 0);
    push_sample(16'h0001, 0); push_sample(16'hFFFF, 1); push_sample(16'h5555, 0);
    push_sample(16'hAAAA, 1);
    settle();
    // Asian, negate on odd scenarios
    configure(64'hFFFF_F000, 30000000, 1050000000, 100 << 16, 95 << 16, 3, 1,
              gbm_pkg::ModeNegOdd);
    for (int i = 0; i < 6; i++) push_sample(16'h1800, i[0]);
    settle();
    // mirrored pair mean
    configure(0, 40000000, 1073741824, 100 << 16, 100 << 16, 2, 0, gbm_pkg::ModePair);
    push_sample(16'h2000, 0); push_sample(16'h7FFF, 1);
    push_sample(16'h8000, 0); push_sample(16'hE000, 1);
    settle();
    // unused mode, zero step count
    configure(5000, 21474836, 1073741824, 100 << 16, 80 << 16, 0, 1, 3);
    push_sample(16'h1000, 1); push_sample(16'hF000, 0);
    settle();
    // price faults: overflow then underflow
    configure(64'h7FFF_FFFF, 0, 1073741824, PMAX - 5, 0, 2, 0, gbm_pkg::ModePlain);
    push_sample(0, 0); push_sample(0, 0);
    settle();
    configure(64'h8000_0000, 64'h7FFF_FFFF, 1073741824, 1, 0, 2, 0, gbm_pkg::ModePair);
    push_sample(16'h8000, 0); push_sample(16'h7FFF, 1);
    settle();
    // payoff saturation
    configure(0, 0, 64'hFFFF_FFFF, PMAX, 0, 1, 0, gbm_pkg::ModePlain);
    push_sample(16'h0000, 0); push_sample(16'h7FFF, 1);
    settle();
    // oversized step count, then lowered mid-path
    configure(0, 10000000, 1073741824, 100 << 16, 90 << 16, 8191, 1, gbm_pkg::ModePlain);
    push_sample(16'h0100, 0); push_sample(16'hFF00, 1); push_sample(16'h0200, 0);
    settle();
    reg_write(gbm_pkg::RegSteps, 2);
    push_sample(16'h0300, 1);
    settle();

    // random phases
    sent = 0;
    for (int ph = 0; sent < 1650; ph++) begin
      int r, cnt;
      r = $urandom_range(0, 99);
      if (r < 70) ns = $urandom_range(1, 8);
      else if (r < 95) ns = $urandom_range(9, 40);
      else ns = ($urandom_range(0, 1) == 0) ? 0 : 4096;
      // short paths while the receiver holds off, so path ends wait on the output register
      if (ph == 2) ns = 2;
      configure(($urandom_range(0, 9) == 0) ? longint'($urandom)
                  : longint'($urandom_range(0, 2000000)) - 1000000,
                ($urandom_range(0, 9) == 0) ? longint'($urandom >> 1)
                  : longint'($urandom_range(0, 60000000)),
                ($urandom_range(0, 9) == 0) ? longint'($urandom)
                  : longint'($urandom_range(858993459, 1073741824)),
                rand_price(), rand_price(), ns, $urandom_range(0, 1),
                $urandom_range(0, 3));
      no_gaps = (ph % 5 == 3);
      if (ph == 2) long_hold_req <= 3000;
      cnt = $urandom_range(60, 110);
      for (int i = 0; i < cnt; i++) push_sample(rand_sample(), $urandom_range(0, 1));
      sent += cnt;
      settle();
    end

    if (mismatches == 0 && expected_payoffs.size() == 0) begin
      $display("gbm_path_option_payoff_unit_test: done, clean");
    end else begin
      $display("gbm_path_option_payoff_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("gbm_path_option_payoff_unit_test: done, errors");
    $finish;
  end

endmodule
